// ----- rtl/mean_diffusivity_from_dw_samples_defines.svh -----
// Assertion macros shared by the mean diffusivity block.
`ifndef MEAN_DIFFUSIVITY_FROM_DW_SAMPLES_DEFINES_SVH
`define MEAN_DIFFUSIVITY_FROM_DW_SAMPLES_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MDFD_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MDFD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/mdfd_pkg.sv -----
// Package with the shared types and constants of the mean diffusivity block.
package mdfd_pkg;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_PASS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ZERO_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TERM   = 2'd2;

  localparam int B_W    = 16;
  localparam int SUM_W  = 40;
  localparam int MEAN_W = 32;
  localparam int DIVR_W = 16;
  localparam int CTR_W  = 6;

  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [19:0] UNIT_SCALE = 20'd1000000;
  localparam logic signed [SUM_W:0] SUM_LIMIT = 41'sd549755813887;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              last;
    logic              t2_zero;
  } ctl_t;

endpackage

// ----- rtl/mean_diffusivity_from_dw_samples.sv -----
// Computed orientations pass through the log, ln, scale, term division and accumulate steps.
// Skipped orientations bypass these steps; a last item adds the final mean step and division.
// Items use the log unit and the shared one-bit-per-cycle divider one at a time.
// A two-entry queue lets the front accept items while the back end computes.
// Synchronous active-high reset clears the run state, the queue and the output valid.
module mean_diffusivity_from_dw_samples
  import mdfd_pkg::*;
#(
  parameter int MAX_ORIENTATIONS = 256,
  parameter int LOG_FRAC_BITS    = 16,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] t2_sample,
  input  logic [15:0] dw_sample,
  input  logic [15:0] b_value,
  input  logic        last_orientation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] adc_mean,
  output logic        t2_was_zero,
  output logic        zero_b_seen
);

  localparam int CW = $clog2(MAX_ORIENTATIONS + 1);
  localparam int EW = 2 * SAMPLE_BITS + B_W + CW + $bits(ctl_t);

  logic                   accept;
  logic                   full;
  logic                   not_empty;
  logic                   pop;
  logic [SAMPLE_BITS-1:0] f_t2, f_dw, b_t2, b_dw;
  logic [B_W-1:0]         f_b, b_b;
  logic [CW-1:0]          f_count, b_count;
  ctl_t                   f_ctl, b_ctl;
  logic [EW-1:0]          push_data, pop_data;

  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;
  assign push_data = {f_t2, f_dw, f_b, f_count, f_ctl};
  assign {b_t2, b_dw, b_b, b_count, b_ctl} = pop_data;

  mdfd_front #(
    .MAX_ORIENTATIONS(MAX_ORIENTATIONS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CW(CW)
  ) u_front (
    .clk(clk), .rst(rst), .accept(accept),
    .t2_sample(t2_sample), .dw_sample(dw_sample), .b_value(b_value),
    .last_orientation(last_orientation),
    .ent_t2(f_t2), .ent_dw(f_dw), .ent_b(f_b), .ent_count(f_count), .ent_ctl(f_ctl)
  );

  mdfd_fifo #(.W(EW)) u_fifo (
    .clk(clk), .rst(rst), .push(accept), .push_data(push_data), .full(full),
    .pop(pop), .pop_data(pop_data), .not_empty(not_empty)
  );

  mdfd_back #(
    .LOG_FRAC_BITS(LOG_FRAC_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CW(CW)
  ) u_back (
    .clk(clk), .rst(rst), .ent_valid(not_empty), .ent_pop(pop),
    .ent_t2(b_t2), .ent_dw(b_dw), .ent_b(b_b), .ent_count(b_count), .ent_ctl(b_ctl),
    .out_valid(out_valid), .out_ready(out_ready),
    .adc_mean(adc_mean), .t2_was_zero(t2_was_zero),
    .zero_b_seen(zero_b_seen)
  );

endmodule

// ----- rtl/mdfd_front.sv -----
// Front end: tracks run boundaries, latches T2, counts and classifies orientations.
module mdfd_front
  import mdfd_pkg::*;
#(
  parameter int MAX_ORIENTATIONS = 256,
  parameter int SAMPLE_BITS      = 16,
  parameter int CW               = $clog2(MAX_ORIENTATIONS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [15:0]            t2_sample,
  input  logic [15:0]            dw_sample,
  input  logic [15:0]            b_value,
  input  logic                   last_orientation,
  output logic [SAMPLE_BITS-1:0] ent_t2,
  output logic [SAMPLE_BITS-1:0] ent_dw,
  output logic [B_W-1:0]         ent_b,
  output logic [CW-1:0]          ent_count,
  output ctl_t                   ent_ctl
);

  logic                   in_run;
  logic [SAMPLE_BITS-1:0] t2;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_base;
  logic                   full;

  always_comb begin
    ent_t2     = in_run ? t2 : SAMPLE_BITS'(t2_sample);
    ent_dw     = SAMPLE_BITS'(dw_sample);
    ent_b      = b_value;
    count_base = in_run ? count : '0;
    full       = (32'(count_base) >= 32'(MAX_ORIENTATIONS));
    ent_count  = full ? count_base : CW'(count_base + 1'b1);
    ent_ctl.last    = last_orientation;
    ent_ctl.t2_zero = (ent_t2 == '0);
    if (full || ent_t2 == '0 || ent_dw == '0) begin
      ent_ctl.kind = KIND_PASS;
    end else if (ent_b == '0) begin
      ent_ctl.kind = KIND_ZERO_B;
    end else begin
      ent_ctl.kind = KIND_TERM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
      count  <= '0;
    end else if (accept) begin
      in_run <= !last_orientation;
      count  <= ent_count;
    end
    if (accept) begin
      t2 <= ent_t2;
    end
  end

endmodule

// ----- rtl/mdfd_fifo.sv -----
// Two-entry queue between the front end and the arithmetic back end.
module mdfd_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   used;

  assign full      = (used == 2'd2);
  assign not_empty = (used != 2'd0);
  assign pop_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      used <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      used <= 2'(used + {1'b0, push} - {1'b0, pop});
    end
    if (push) begin
      mem[wp] <= push_data;
    end
  end

endmodule

// ----- rtl/mdfd_back.sv -----
// Back end: fixed-point logs, term division, accumulation and the final mean.
module mdfd_back
  import mdfd_pkg::*;
#(
  parameter int LOG_FRAC_BITS    = 16,
  parameter int SAMPLE_BITS      = 16,
  parameter int CW               = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ent_valid,
  output logic                   ent_pop,
  input  logic [SAMPLE_BITS-1:0] ent_t2,
  input  logic [SAMPLE_BITS-1:0] ent_dw,
  input  logic [B_W-1:0]         ent_b,
  input  logic [CW-1:0]          ent_count,
  input  ctl_t                   ent_ctl,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [MEAN_W-1:0]      adc_mean,
  output logic                   t2_was_zero,
  output logic                   zero_b_seen
);

`include "mean_diffusivity_from_dw_samples_defines.svh"

  localparam int F  = LOG_FRAC_BITS;
  localparam int KW = $clog2(SAMPLE_BITS);
  localparam int MW = KW + F;
  localparam int NW = KW + 20;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOG  = 3'd1;
  localparam logic [2:0] S_LN   = 3'd2;
  localparam logic [2:0] S_SC   = 3'd3;
  localparam logic [2:0] S_TDIV = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_MDIV = 3'd7;

  logic [2:0]               state;
  logic                     emit;
  logic [CTR_W-1:0]         ctr;
  logic                     last;
  logic                     t2_zero;
  logic [CW-1:0]            count;
  logic [B_W-1:0]           b;
  logic [KW-1:0]            kt;
  logic [KW-1:0]            kd;
  logic [31:0]              mt;
  logic [31:0]              md;
  logic [F-1:0]             ft;
  logic [F-1:0]             fd;
  logic                     neg;
  logic [MW-1:0]            lnm;
  logic [SUM_W-1:0]         dvd;
  logic [SUM_W-1:0]         quo;
  logic [DIVR_W-1:0]        dvr;
  logic [DIVR_W-1:0]        rem;
  logic signed [SUM_W-1:0]  sum;
  logic                     zb_flag;

  logic [KW-1:0]     kt_new;
  logic [KW-1:0]     kd_new;
  logic [63:0]       sq_t;
  logic [63:0]       sq_d;
  logic [MW-1:0]     l2t;
  logic [MW-1:0]     l2d;
  logic [MW-1:0]     mag;
  logic [MW+31:0]    ln_prod;
  logic [MW+19:0]    sc_prod;
  logic [DIVR_W:0]   trial;
  logic              take;
  logic signed [SUM_W:0] acc;
  logic              out_free;

  function automatic logic [KW-1:0] msb_index(input logic [SAMPLE_BITS-1:0] x);
    logic [KW-1:0] k;
    k = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (x[i]) k = KW'(i);
    end
    return k;
  endfunction

  always_comb begin
    kt_new   = msb_index(ent_t2);
    kd_new   = msb_index(ent_dw);
    sq_t     = mt * mt;
    sq_d     = md * md;
    l2t      = {kt, ft};
    l2d      = {kd, fd};
    mag      = (l2d > l2t) ? MW'(l2d - l2t) : MW'(l2t - l2d);
    ln_prod  = MW'(mag) * LN2_Q32 + (MW+32)'(64'h8000_0000);
    sc_prod  = lnm * UNIT_SCALE;
    trial    = {rem, dvd[SUM_W-1]};
    take     = (trial >= {1'b0, dvr});
    acc      = neg ? ((SUM_W+1)'(sum) - $signed({1'b0, quo}))
                   : ((SUM_W+1)'(sum) + $signed({1'b0, quo}));
    out_free = !out_valid || out_ready;
    ent_pop  = (state == S_IDLE) && !emit && ent_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit      <= 1'b0;
      out_valid <= 1'b0;
      sum       <= '0;
      zb_flag   <= 1'b0;
      ctr       <= '0;
    end else begin
      if (emit && out_free) begin
        out_valid   <= 1'b1;
        t2_was_zero <= t2_zero;
        zero_b_seen <= zb_flag;
        emit        <= 1'b0;
        sum         <= '0;
        zb_flag     <= 1'b0;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ent_pop) begin
            last    <= ent_ctl.last;
            t2_zero <= ent_ctl.t2_zero;
            count   <= ent_count;
            b       <= ent_b;
            if (ent_ctl.kind == KIND_ZERO_B) zb_flag <= 1'b1;
            if (ent_ctl.kind == KIND_TERM) begin
              kt    <= kt_new;
              kd    <= kd_new;
              mt    <= 32'(32'(ent_t2) << (5'd31 - 5'(kt_new)));
              md    <= 32'(32'(ent_dw) << (5'd31 - 5'(kd_new)));
              ctr   <= CTR_W'(F);
              state <= S_LOG;
            end else if (ent_ctl.last) begin
              state <= S_FIN;
            end
          end
        end
        S_LOG: begin
          // One fraction bit of each log per cycle by squaring the mantissa.
          ft  <= {ft[F-2:0], sq_t[63]};
          fd  <= {fd[F-2:0], sq_d[63]};
          mt  <= sq_t[63] ? sq_t[63:32] : sq_t[62:31];
          md  <= sq_d[63] ? sq_d[63:32] : sq_d[62:31];
          ctr <= CTR_W'(ctr - 1'b1);
          if (ctr == CTR_W'(1)) state <= S_LN;
        end
        S_LN: begin
          neg   <= (l2d > l2t);
          lnm   <= ln_prod[MW+31:32];
          state <= S_SC;
        end
        S_SC: begin
          dvd   <= {sc_prod[MW+19:F], (SUM_W-NW)'(0)};
          dvr   <= b;
          rem   <= '0;
          quo   <= '0;
          ctr   <= CTR_W'(NW);
          state <= S_TDIV;
        end
        S_TDIV, S_MDIV: begin
          // Restoring division, one quotient bit per cycle.
          dvd <= {dvd[SUM_W-2:0], 1'b0};
          rem <= take ? DIVR_W'(trial - {1'b0, dvr}) : trial[DIVR_W-1:0];
          quo <= {quo[SUM_W-2:0], take};
          ctr <= CTR_W'(ctr - 1'b1);
          if (ctr == CTR_W'(1)) state <= (state == S_TDIV) ? S_ACC : S_IDLE;
          if (ctr == CTR_W'(1) && state == S_MDIV) emit <= 1'b1;
        end
        S_ACC: begin
          if (acc > SUM_LIMIT) sum <= SUM_W'(SUM_LIMIT);
          else if (acc < -SUM_LIMIT) sum <= SUM_W'(-SUM_LIMIT);
          else sum <= SUM_W'(acc);
          state <= last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (!t2_zero && sum > 0 && count != '0) begin
            dvd   <= sum;
            dvr   <= DIVR_W'(count);
            rem   <= '0;
            quo   <= '0;
            ctr   <= CTR_W'(SUM_W);
            state <= S_MDIV;
          end else begin
            quo   <= '0;
            emit  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (emit && out_free) begin
      adc_mean <= (quo[SUM_W-1:MEAN_W] != '0) ? '1 : quo[MEAN_W-1:0];
    end
  end

  `MDFD_ASSERT_NOW(a_pop_idle, clk, rst, ent_pop, state == S_IDLE && !emit, "request taken while busy")
  `MDFD_ASSERT_NOW(a_ctr_live, clk, rst, state == S_LOG || state == S_TDIV || state == S_MDIV, ctr != '0, "iteration counter ran out")
  `MDFD_ASSERT_NEXT(a_emit_clear, clk, rst, emit && out_free, sum == '0 && !zb_flag && out_valid, "run state not cleared on result")

endmodule

// ----- tb/mean_diffusivity_from_dw_samples_tb.sv -----
// Self-checking testbench for the mean diffusivity block: directed and random runs of orientations.
module mean_diffusivity_from_dw_samples_tb;
  import mdfd_pkg::*;

  localparam int MAX_ORI = 256;
  localparam int FRAC = 16;
  localparam longint SUM_MAX = 64'sd549755813887;

  typedef struct packed {
    logic [15:0] t2;
    logic [15:0] dw;
    logic [15:0] b;
    logic        last;
  } request_t;

  typedef struct packed {
    logic [31:0] mean;
    logic        t2_zero;
    logic        zero_b;
  } voxel_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] t2_sample;
  logic [15:0] dw_sample;
  logic [15:0] b_value;
  logic        last_orientation;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] adc_mean;
  logic        t2_was_zero;
  logic        zero_b_seen;

  mean_diffusivity_from_dw_samples dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .t2_sample(t2_sample), .dw_sample(dw_sample), .b_value(b_value),
    .last_orientation(last_orientation),
    .out_valid(out_valid), .out_ready(out_ready),
    .adc_mean(adc_mean), .t2_was_zero(t2_was_zero),
    .zero_b_seen(zero_b_seen)
  );

  request_t      pending_requests[$];
  voxel_result_t expected_means[$];
  int            error_count;
  int            send_idle_pct;
  int            recv_stall_pct;
  bit            hold_off;
  bit            drain_pause;
  int            hold_cycles;

  // Predictor state for the voxel in progress.
  logic [15:0]    run_t2;
  longint         run_sum;
  int             run_count;
  bit             run_active;
  bit             run_zero_b;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned log2_q(input logic [15:0] x);
    int             k;
    longint unsigned m;
    longint unsigned acc;
    k = 0;
    while (k < 31 && (32'(x) >> (k + 1)) != 0) k++;
    m = (64'(x) << (31 - k)) & 64'hFFFF_FFFF;
    acc = 64'(k) << FRAC;
    for (int i = FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd2 << 31)) begin
        acc |= 64'd1 << i;
        m >>= 1;
      end
    end
    return acc;
  endfunction

  task automatic predict_mean(input request_t r);
    longint unsigned lt, ld, mag, lnm, term;
    bit              neg;
    voxel_result_t   res;
    if (!run_active) begin
      run_t2 = r.t2;
      run_sum = 0;
      run_count = 0;
      run_zero_b = 1'b0;
      run_active = 1'b1;
    end
    if (run_count < MAX_ORI) begin
      run_count++;
      if (run_t2 != 0 && r.dw != 0) begin
        if (r.b == 0) begin
          run_zero_b = 1'b1;
        end else begin
          lt = log2_q(run_t2);
          ld = log2_q(r.dw);
          neg = ld > lt;
          mag = neg ? ld - lt : lt - ld;
          lnm = (mag * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
          term = (lnm * 64'd1000000) / (64'(r.b) << FRAC);
          run_sum = neg ? run_sum - longint'(term) : run_sum + longint'(term);
          if (run_sum > SUM_MAX) run_sum = SUM_MAX;
          if (run_sum < -SUM_MAX) run_sum = -SUM_MAX;
        end
      end
    end
    if (r.last) begin
      res.mean = 32'd0;
      if (run_t2 != 0 && run_sum > 0 && run_count != 0) begin
        term = longint'(run_sum) / longint'(run_count);
        res.mean = (term > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : term[31:0];
      end
      res.t2_zero = (run_t2 == 0);
      res.zero_b = run_zero_b;
      expected_means.push_back(res);
      run_active = 1'b0;
    end
  endtask

  // Driver: offers the next pending request, idling at random between requests.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_mean({t2_sample, dw_sample, b_value, last_orientation});
      if (pending_requests.size() != 0 && !drain_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        {t2_sample, dw_sample, b_value, last_orientation} <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected result mean=%0d t2z=%0b zb=%0b", $time,
                   adc_mean, t2_was_zero, zero_b_seen);
          error_count++;
        end else begin
          voxel_result_t e;
          e = expected_means.pop_front();
          if (adc_mean !== e.mean) begin
            $display("%0t: adc_mean expected %0d actual %0d", $time, e.mean,
                     adc_mean);
            error_count++;
          end
          if (t2_was_zero !== e.t2_zero) begin
            $display("%0t: t2_was_zero expected %0b actual %0b", $time, e.t2_zero,
                     t2_was_zero);
            error_count++;
          end
          if (zero_b_seen !== e.zero_b) begin
            $display("%0t: zero_b_seen expected %0b actual %0b", $time, e.zero_b,
                     zero_b_seen);
            error_count++;
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    hold_off = 1'b0;
    wait (hold_cycles != 0);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (hold_cycles) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic request_t random_request(input logic [15:0] t2, input bit last);
    request_t r;
    r.t2 = t2;
    case ($urandom_range(9))
      0: r.dw = 16'd0;
      1: r.dw = 16'(1 << $urandom_range(15));
      2: r.dw = 16'hFFFF;
      default: r.dw = t2 == 0 ? 16'($urandom) : 16'(t2 >> $urandom_range(4));
    endcase
    if ($urandom_range(7) == 0) r.dw = 16'($urandom);
    case ($urandom_range(11))
      0: r.b = 16'd0;
      1: r.b = 16'd1;
      2: r.b = 16'($urandom);
      default: r.b = 16'($urandom_range(4000, 100));
    endcase
    r.last = last;
    return r;
  endfunction

  task automatic queue_voxel(input int n);
    logic [15:0] t2;
    case ($urandom_range(15))
      0: t2 = 16'd0;
      1: t2 = 16'hFFFF;
      2: t2 = 16'd1;
      default: t2 = 16'($urandom);
    endcase
    for (int i = 0; i < n; i++) begin
      pending_requests.push_back(random_request(i == 0 ? t2 : 16'($urandom), i == n - 1));
    end
  endtask

  task automatic wait_drained;
    wait (pending_requests.size() == 0 && !in_valid && expected_means.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int n;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_pause = 1'b0;
    hold_cycles = 0;
    run_active = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    t2_sample = '0;
    dw_sample = '0;
    b_value = '0;
    last_orientation = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: run of one, zero T2, zero DW, zero b, DW above T2, extremes.
    pending_requests.push_back({16'd1000, 16'd500, 16'd1000, 1'b1});
    pending_requests.push_back({16'd0, 16'd500, 16'd0, 1'b1});
    pending_requests.push_back({16'd800, 16'd0, 16'd1000, 1'b1});
    pending_requests.push_back({16'd800, 16'd400, 16'd0, 1'b0});
    pending_requests.push_back({16'd5, 16'd400, 16'd1000, 1'b1});
    pending_requests.push_back({16'hFFFF, 16'd1, 16'd1, 1'b0});
    pending_requests.push_back({16'h0000, 16'd1, 16'd1, 1'b0});
    pending_requests.push_back({16'h0000, 16'hFFFF, 16'hFFFF, 1'b1});
    pending_requests.push_back({16'd1, 16'hFFFF, 16'd1, 1'b1});
    pending_requests.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
    pending_requests.push_back({16'hAAAA, 16'h5555, 16'hAAAA, 1'b0});
    pending_requests.push_back({16'h5555, 16'hAAAA, 16'h5555, 1'b1});
    wait_drained();

    // Orientation limit: a voxel with more orientations than MAX_ORIENTATIONS.
    for (int i = 0; i < 270; i++)
      pending_requests.push_back({16'd3000, 16'(100 + i), 16'd1000, i == 269});
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 71 : 24) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 71 : 24) : 0;
      for (int v = 0; v < 40; v++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(8, 1);
        queue_voxel(n);
      end
      if (phase == 0) hold_cycles = 3000;
      wait_drained();
    end

    // The sender pauses until every result has come, then resumes.
    for (int v = 0; v < 10; v++) queue_voxel($urandom_range(3, 1));
    drain_pause = 1'b1;
    wait (expected_means.size() == 0 && !in_valid);
    repeat (50) @(posedge clk);
    drain_pause = 1'b0;
    wait_drained();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
